// File: hw/rtl/nrsh_pkg.sv
// Package for the nearest ray/sphere hit block: widths, command codes,
// product selects and the controller/datapath command and status structs.
// No dependencies.
package nrsh_pkg;

    localparam int MAX_SPHERES = 64;
    localparam int IDX_W       = $clog2(MAX_SPHERES);
    localparam int CNT_W       = $clog2(MAX_SPHERES + 1);

    localparam int CMD_W   = 2;
    localparam int POS_W   = 32;
    localparam int RAD_W   = 31;
    localparam int DIR_W   = 18;
    localparam int DIST_W  = 31;
    localparam int HIDX_W  = 6;

    localparam logic [DIST_W-1:0] MAX_DIST_RESET = 31'd655360000;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CAST   = 2'd2;

    // internal arithmetic widths
    localparam int W_W        = POS_W + 1;           // o - c
    localparam int H_W        = 52;                  // u.w
    localparam int D_W        = 104;                 // discriminant, signed
    localparam int MUL_W      = 52;                  // multiplier operands
    localparam int DIG_W      = 13;                  // digit per multiply step
    localparam int MUL_DIGITS = MUL_W / DIG_W;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ROOT_W     = D_W / 2;
    localparam int SQ_STEPS   = ROOT_W;
    localparam int REM_W      = ROOT_W + 4;
    localparam int T_W        = ROOT_W + 2;
    localparam int DT_W       = T_W - 16;
    localparam int STEP_W     = $clog2(SQ_STEPS);
    localparam int FRAC_SH    = 32;

    localparam int SEL_W = 3;
    localparam logic [SEL_W-1:0] PS_HX = 3'd0;
    localparam logic [SEL_W-1:0] PS_HY = 3'd1;
    localparam logic [SEL_W-1:0] PS_HZ = 3'd2;
    localparam logic [SEL_W-1:0] PS_HH = 3'd3;
    localparam logic [SEL_W-1:0] PS_RR = 3'd4;
    localparam logic [SEL_W-1:0] PS_WX = 3'd5;
    localparam logic [SEL_W-1:0] PS_WY = 3'd6;
    localparam logic [SEL_W-1:0] PS_WZ = 3'd7;

    typedef struct packed {
        logic signed [POS_W-1:0] cx;
        logic signed [POS_W-1:0] cy;
        logic signed [POS_W-1:0] cz;
        logic        [RAD_W-1:0] r;
    } sphere_t;

    typedef struct packed {
        logic             load_in;
        logic             clear;
        logic             append;
        logic             rd;
        logic             wcalc;
        logic             mload;
        logic             mstep;
        logic             macc;
        logic             sqload;
        logic             sqstep;
        logic             eval;
        logic             out_load;
        logic [SEL_W-1:0] sel;
        logic [IDX_W-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [CNT_W-1:0] count;
        logic             dsum_neg;
    } dp_sts_t;

endpackage

// File: hw/rtl/nrsh_datapath.sv
// Datapath: sphere memory, count, max_distance register, shared digit-serial
// multiplier, bit-serial square root, nearest-hit tracking and result register.
// Depends on nrsh_pkg.
module nrsh_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [nrsh_pkg::DIST_W-1:0]   cfg_wr_data,
    input  logic [nrsh_pkg::CMD_W-1:0]    s_cmd,
    input  logic signed [nrsh_pkg::POS_W-1:0] s_pos_x,
    input  logic signed [nrsh_pkg::POS_W-1:0] s_pos_y,
    input  logic signed [nrsh_pkg::POS_W-1:0] s_pos_z,
    input  logic [nrsh_pkg::RAD_W-1:0]    s_radius,
    input  logic signed [nrsh_pkg::DIR_W-1:0] s_dir_x,
    input  logic signed [nrsh_pkg::DIR_W-1:0] s_dir_y,
    input  logic signed [nrsh_pkg::DIR_W-1:0] s_dir_z,
    input  nrsh_pkg::dp_cmd_t             dp_cmd,
    output nrsh_pkg::dp_sts_t             dp_sts,
    output logic                          m_hit,
    output logic [nrsh_pkg::HIDX_W-1:0]   m_hit_index,
    output logic [nrsh_pkg::DIST_W-1:0]   m_hit_distance,
    output logic                          m_table_full
);
    import nrsh_pkg::*;

    sphere_t sph_mem [MAX_SPHERES];
    sphere_t rd_data_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [DIST_W-1:0] max_dist_reg;
    logic              full;

    logic [CMD_W-1:0]        cmd_reg;
    logic signed [POS_W-1:0] ox_reg, oy_reg, oz_reg;
    logic [RAD_W-1:0]        rad_in_reg;
    logic signed [DIR_W-1:0] ux_reg, uy_reg, uz_reg;

    logic signed [W_W-1:0] wx_reg, wy_reg, wz_reg;
    logic signed [H_W-1:0] h_reg;
    logic signed [D_W-1:0] dsum_reg;

    logic [MUL_W-1:0]       mul_a_reg, mul_b_reg;
    logic                   neg_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [MUL_W+DIG_W-1:0] mul_part;
    logic [MUL_W-1:0]       mul_a_next, mul_b_next;
    logic                   neg_next;

    logic [W_W-1:0]   abs_wx, abs_wy, abs_wz;
    logic [DIR_W-1:0] abs_ux, abs_uy, abs_uz;
    logic [H_W-1:0]   abs_h;

    logic [D_W-1:0]    rad_reg;
    logic [REM_W-1:0]  rem_reg, rem_sh, trial;
    logic [ROOT_W-1:0] root_reg;

    logic signed [T_W-1:0] h_ext, s_ext, t1, t2, t_sel;
    logic [DT_W-1:0]       dist_t;
    logic                  t_hit;

    logic [DIST_W-1:0] best_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic              hit_reg, full_flag_reg;

    logic              m_hit_reg, m_full_reg;
    logic [HIDX_W-1:0] m_idx_reg;
    logic [DIST_W-1:0] m_dist_reg;

    assign full = (count_reg == CNT_W'(MAX_SPHERES));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            max_dist_reg <= MAX_DIST_RESET;
        end else begin
            if (cfg_wr_en) begin
                max_dist_reg <= cfg_wr_data;
            end
            if (dp_cmd.clear) begin
                count_reg <= '0;
            end else if (dp_cmd.append && !full) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.append && !full) begin
            sph_mem[count_reg[IDX_W-1:0]] <= '{cx: ox_reg, cy: oy_reg, cz: oz_reg, r: rad_in_reg};
        end
        if (dp_cmd.rd) begin
            rd_data_reg <= sph_mem[dp_cmd.idx];
        end
    end

    assign abs_wx = wx_reg[W_W-1] ? W_W'(-wx_reg) : W_W'(wx_reg);
    assign abs_wy = wy_reg[W_W-1] ? W_W'(-wy_reg) : W_W'(wy_reg);
    assign abs_wz = wz_reg[W_W-1] ? W_W'(-wz_reg) : W_W'(wz_reg);
    assign abs_ux = ux_reg[DIR_W-1] ? DIR_W'(-ux_reg) : DIR_W'(ux_reg);
    assign abs_uy = uy_reg[DIR_W-1] ? DIR_W'(-uy_reg) : DIR_W'(uy_reg);
    assign abs_uz = uz_reg[DIR_W-1] ? DIR_W'(-uz_reg) : DIR_W'(uz_reg);
    assign abs_h  = h_reg[H_W-1] ? H_W'(-h_reg) : H_W'(h_reg);

    always_comb begin
        mul_a_next = '0;
        mul_b_next = '0;
        neg_next   = 1'b0;
        case (dp_cmd.sel)
            PS_HX: begin
                mul_a_next = MUL_W'(abs_wx);
                mul_b_next = MUL_W'(abs_ux);
                neg_next   = wx_reg[W_W-1] ^ ux_reg[DIR_W-1];
            end
            PS_HY: begin
                mul_a_next = MUL_W'(abs_wy);
                mul_b_next = MUL_W'(abs_uy);
                neg_next   = wy_reg[W_W-1] ^ uy_reg[DIR_W-1];
            end
            PS_HZ: begin
                mul_a_next = MUL_W'(abs_wz);
                mul_b_next = MUL_W'(abs_uz);
                neg_next   = wz_reg[W_W-1] ^ uz_reg[DIR_W-1];
            end
            PS_HH: begin
                mul_a_next = MUL_W'(abs_h);
                mul_b_next = MUL_W'(abs_h);
            end
            PS_RR: begin
                mul_a_next = MUL_W'(rd_data_reg.r);
                mul_b_next = MUL_W'(rd_data_reg.r);
            end
            PS_WX: begin
                mul_a_next = MUL_W'(abs_wx);
                mul_b_next = MUL_W'(abs_wx);
            end
            PS_WY: begin
                mul_a_next = MUL_W'(abs_wy);
                mul_b_next = MUL_W'(abs_wy);
            end
            PS_WZ: begin
                mul_a_next = MUL_W'(abs_wz);
                mul_b_next = MUL_W'(abs_wz);
            end
            default: begin
                mul_a_next = '0;
                mul_b_next = '0;
            end
        endcase
    end

    assign mul_part = mul_a_reg * mul_b_reg[MUL_W-1 -: DIG_W];

    // restoring square root, two radicand bits per step
    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[D_W-1 -: 2]};
    assign trial  = REM_W'({root_reg, 2'b01});

    assign h_ext  = T_W'(h_reg);
    assign s_ext  = T_W'(root_reg);
    assign t1     = -h_ext - s_ext;
    assign t2     = -h_ext + s_ext;
    assign t_hit  = !t1[T_W-1] || !t2[T_W-1];
    assign t_sel  = !t1[T_W-1] ? t1 : t2;
    assign dist_t = t_sel[T_W-1:16];

    always_ff @(posedge aclk) begin
        if (dp_cmd.load_in) begin
            cmd_reg       <= s_cmd;
            ox_reg        <= s_pos_x;
            oy_reg        <= s_pos_y;
            oz_reg        <= s_pos_z;
            rad_in_reg    <= s_radius;
            ux_reg        <= s_dir_x;
            uy_reg        <= s_dir_y;
            uz_reg        <= s_dir_z;
            best_reg      <= max_dist_reg;
            best_idx_reg  <= '0;
            hit_reg       <= 1'b0;
            full_flag_reg <= 1'b0;
        end
        if (dp_cmd.append && full) begin
            full_flag_reg <= 1'b1;
        end
        if (dp_cmd.wcalc) begin
            wx_reg   <= W_W'(ox_reg) - W_W'(rd_data_reg.cx);
            wy_reg   <= W_W'(oy_reg) - W_W'(rd_data_reg.cy);
            wz_reg   <= W_W'(oz_reg) - W_W'(rd_data_reg.cz);
            h_reg    <= '0;
            dsum_reg <= '0;
        end
        if (dp_cmd.mload) begin
            mul_a_reg <= mul_a_next;
            mul_b_reg <= mul_b_next;
            neg_reg   <= neg_next;
            prod_reg  <= '0;
        end
        if (dp_cmd.mstep) begin
            prod_reg  <= (prod_reg << DIG_W) + PROD_W'(mul_part);
            mul_b_reg <= mul_b_reg << DIG_W;
        end
        if (dp_cmd.macc) begin
            case (dp_cmd.sel)
                PS_HX, PS_HY, PS_HZ: begin
                    h_reg <= neg_reg ? h_reg - H_W'(prod_reg) : h_reg + H_W'(prod_reg);
                end
                PS_HH: begin
                    dsum_reg <= dsum_reg + D_W'(prod_reg);
                end
                PS_RR: begin
                    dsum_reg <= dsum_reg + (D_W'(prod_reg) << FRAC_SH);
                end
                default: begin
                    dsum_reg <= dsum_reg - (D_W'(prod_reg) << FRAC_SH);
                end
            endcase
        end
        if (dp_cmd.sqload) begin
            rad_reg  <= D_W'(dsum_reg);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (dp_cmd.sqstep) begin
            rad_reg <= rad_reg << 2;
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (dp_cmd.eval && t_hit && (dist_t < DT_W'(best_reg))) begin
            best_reg     <= DIST_W'(dist_t);
            best_idx_reg <= dp_cmd.idx;
            hit_reg      <= 1'b1;
        end
        if (dp_cmd.out_load) begin
            m_hit_reg  <= hit_reg;
            m_idx_reg  <= HIDX_W'(best_idx_reg);
            m_dist_reg <= best_reg;
            m_full_reg <= full_flag_reg;
        end
    end

    assign dp_sts.cmd      = cmd_reg;
    assign dp_sts.count    = count_reg;
    assign dp_sts.dsum_neg = dsum_reg[D_W-1];

    assign m_hit          = m_hit_reg;
    assign m_hit_index    = m_idx_reg;
    assign m_hit_distance = m_dist_reg;
    assign m_table_full   = m_full_reg;

endmodule

// File: hw/rtl/nrsh_ctrl.sv
// Controller: state machine sequencing table commands and the per-sphere
// multiply / square-root steps, and the result beat handshake.
// Depends on nrsh_pkg.
module nrsh_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output nrsh_pkg::dp_cmd_t dp_cmd,
    input  nrsh_pkg::dp_sts_t dp_sts
);
    import nrsh_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DISP  = 4'd1;
    localparam logic [3:0] ST_RD    = 4'd2;
    localparam logic [3:0] ST_WCALC = 4'd3;
    localparam logic [3:0] ST_MLOAD = 4'd4;
    localparam logic [3:0] ST_MSTEP = 4'd5;
    localparam logic [3:0] ST_MACC  = 4'd6;
    localparam logic [3:0] ST_CHECK = 4'd7;
    localparam logic [3:0] ST_SQRT  = 4'd8;
    localparam logic [3:0] ST_EVAL  = 4'd9;
    localparam logic [3:0] ST_NEXT  = 4'd10;
    localparam logic [3:0] ST_DONE  = 4'd11;

    logic [3:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [SEL_W-1:0] sel_reg, sel_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic             m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            sel_reg     <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            sel_reg     <= sel_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        sel_next     = sel_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg && !m_ready;
        dp_cmd       = '0;
        dp_cmd.sel   = sel_reg;
        dp_cmd.idx   = idx_reg;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    dp_cmd.load_in = 1'b1;
                    state_next     = ST_DISP;
                end
            end
            ST_DISP: begin
                case (dp_sts.cmd)
                    CMD_CLEAR: begin
                        dp_cmd.clear = 1'b1;
                        state_next   = ST_DONE;
                    end
                    CMD_APPEND: begin
                        dp_cmd.append = 1'b1;
                        state_next    = ST_DONE;
                    end
                    CMD_CAST: begin
                        idx_next   = '0;
                        state_next = (dp_sts.count == '0) ? ST_DONE : ST_RD;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_RD: begin
                dp_cmd.rd  = 1'b1;
                state_next = ST_WCALC;
            end
            ST_WCALC: begin
                dp_cmd.wcalc = 1'b1;
                sel_next     = PS_HX;
                state_next   = ST_MLOAD;
            end
            ST_MLOAD: begin
                dp_cmd.mload = 1'b1;
                step_next    = '0;
                state_next   = ST_MSTEP;
            end
            ST_MSTEP: begin
                dp_cmd.mstep = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(MUL_DIGITS - 1)) begin
                    state_next = ST_MACC;
                end
            end
            ST_MACC: begin
                dp_cmd.macc = 1'b1;
                if (sel_reg == PS_WZ) begin
                    state_next = ST_CHECK;
                end else begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = ST_MLOAD;
                end
            end
            ST_CHECK: begin
                if (dp_sts.dsum_neg) begin
                    state_next = ST_NEXT;
                end else begin
                    dp_cmd.sqload = 1'b1;
                    step_next     = '0;
                    state_next    = ST_SQRT;
                end
            end
            ST_SQRT: begin
                dp_cmd.sqstep = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_W'(SQ_STEPS - 1)) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                dp_cmd.eval = 1'b1;
                state_next  = ST_NEXT;
            end
            ST_NEXT: begin
                if (CNT_W'(idx_reg) + 1'b1 == dp_sts.count) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    dp_cmd.out_load = 1'b1;
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

// File: hw/rtl/nearest_ray_sphere_hit.sv
// Nearest ray/sphere hit, top level: joins the controller and the datapath.
// Depends on nrsh_pkg, nrsh_ctrl and nrsh_datapath.
//
// Clear and append beats are loaded, dispatched and answered. A cast
// tests the stored spheres one at a time on a single shared datapath: per
// sphere one memory read, one subtract, eight products on a 52x13
// digit-serial multiplier and, unless the discriminant is negative, a
// 52-step bit-serial square root. One beat is worked at a time; a new beat
// is taken while the previous result waits. max_distance is written
// through cfg_wr_en/cfg_wr_data; the user must write it only while idle,
// which the block itself does not enforce.
module nearest_ray_sphere_hit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [nrsh_pkg::DIST_W-1:0]       cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [nrsh_pkg::CMD_W-1:0]        s_cmd,
    input  logic signed [nrsh_pkg::POS_W-1:0] s_pos_x,
    input  logic signed [nrsh_pkg::POS_W-1:0] s_pos_y,
    input  logic signed [nrsh_pkg::POS_W-1:0] s_pos_z,
    input  logic [nrsh_pkg::RAD_W-1:0]        s_radius,
    input  logic signed [nrsh_pkg::DIR_W-1:0] s_dir_x,
    input  logic signed [nrsh_pkg::DIR_W-1:0] s_dir_y,
    input  logic signed [nrsh_pkg::DIR_W-1:0] s_dir_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic [nrsh_pkg::HIDX_W-1:0]       m_hit_index,
    output logic [nrsh_pkg::DIST_W-1:0]       m_hit_distance,
    output logic                              m_table_full
);
    import nrsh_pkg::*;

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    nrsh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dp_cmd  (dp_cmd),
        .dp_sts  (dp_sts)
    );

    nrsh_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_cmd          (s_cmd),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_pos_z        (s_pos_z),
        .s_radius       (s_radius),
        .s_dir_x        (s_dir_x),
        .s_dir_y        (s_dir_y),
        .s_dir_z        (s_dir_z),
        .dp_cmd         (dp_cmd),
        .dp_sts         (dp_sts),
        .m_hit          (m_hit),
        .m_hit_index    (m_hit_index),
        .m_hit_distance (m_hit_distance),
        .m_table_full   (m_table_full)
    );

endmodule

// File: tb/nearest_ray_sphere_hit_tb.sv
// Testbench for nearest_ray_sphere_hit: a directed table, then random clear, sphere,
// ray and noise beats, each result checked by a bit-exact closest-hit predictor.
// Depends on nrsh_pkg and nearest_ray_sphere_hit.
module nearest_ray_sphere_hit_tb;
    import nrsh_pkg::*;

    localparam int Q        = 65536;
    localparam int WD_LIMIT = 40000;
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]        cmd;
        logic signed [POS_W-1:0] px, py, pz;
        logic [RAD_W-1:0]        rad;
        logic signed [DIR_W-1:0] dx, dy, dz;
    } beat_t;

    typedef struct packed {
        logic              hit;
        logic [HIDX_W-1:0] idx;
        logic [DIST_W-1:0] distance;
        logic              full;
    } hit_t;

    typedef struct {
        beat_t b;
        bit    typed;
        hit_t  r;
    } row_t;

    logic aclk, aresetn;
    logic cfg_wr_en;
    logic [DIST_W-1:0] cfg_wr_data;
    logic s_valid, s_ready;
    logic [CMD_W-1:0] s_cmd;
    logic signed [POS_W-1:0] s_pos_x, s_pos_y, s_pos_z;
    logic [RAD_W-1:0] s_radius;
    logic signed [DIR_W-1:0] s_dir_x, s_dir_y, s_dir_z;
    logic m_valid, m_ready;
    logic m_hit, m_table_full;
    logic [HIDX_W-1:0] m_hit_index;
    logic [DIST_W-1:0] m_hit_distance;

    nearest_ray_sphere_hit uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .s_radius(s_radius), .s_dir_x(s_dir_x), .s_dir_y(s_dir_y), .s_dir_z(s_dir_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit),
        .m_hit_index(m_hit_index), .m_hit_distance(m_hit_distance),
        .m_table_full(m_table_full)
    );

    // predictor state
    logic signed [POS_W-1:0] ctr_x[MAX_SPHERES], ctr_y[MAX_SPHERES], ctr_z[MAX_SPHERES];
    logic [RAD_W-1:0] rad_tbl[MAX_SPHERES];
    int sphere_cnt;
    logic [DIST_W-1:0] dist_limit;

    hit_t hit_expect_q[$];
    int   err_cnt;
    bit   calm;
    int   idle_cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] root_floor(logic [127:0] d);
        logic [63:0]  res, cand;
        logic [127:0] sq;
        res = '0;
        for (int k = 53; k >= 0; k--) begin
            cand = res | (64'd1 << k);
            sq   = 128'(cand) * 128'(cand);
            if (!(d < sq)) res = cand;
        end
        return res;
    endfunction

    // distance along the ray to sphere i, -1 on a miss
    function automatic longint sphere_dist(beat_t b, int i);
        longint wx, wy, wz, h, t1, t2;
        logic [127:0] ax, ay, az, ah, ww, p, q;
        logic [63:0] s;
        wx = longint'(b.px) - longint'(ctr_x[i]);
        wy = longint'(b.py) - longint'(ctr_y[i]);
        wz = longint'(b.pz) - longint'(ctr_z[i]);
        h  = longint'(b.dx) * wx + longint'(b.dy) * wy + longint'(b.dz) * wz;
        ax = 128'(wx < 0 ? -wx : wx);
        ay = 128'(wy < 0 ? -wy : wy);
        az = 128'(wz < 0 ? -wz : wz);
        ah = 128'(h < 0 ? -h : h);
        ww = ax * ax + ay * ay + az * az;
        p  = ah * ah + ((128'(rad_tbl[i]) * 128'(rad_tbl[i])) << 32);
        q  = ww << 32;
        if (p < q) return -1;
        s  = root_floor(p - q);
        t1 = -h - longint'(s);
        t2 = -h + longint'(s);
        if (t1 >= 0) return t1 >>> 16;
        if (t2 >= 0) return t2 >>> 16;
        return -1;
    endfunction

    function automatic hit_t nearest_hit_predict(beat_t b);
        hit_t   r;
        longint best, d;
        r.hit = 0; r.idx = '0; r.full = 0;
        best = longint'(dist_limit);
        case (b.cmd)
            CMD_CLEAR: sphere_cnt = 0;
            CMD_APPEND: begin
                if (sphere_cnt < MAX_SPHERES) begin
                    ctr_x[sphere_cnt] = b.px; ctr_y[sphere_cnt] = b.py;
                    ctr_z[sphere_cnt] = b.pz; rad_tbl[sphere_cnt] = b.rad;
                    sphere_cnt++;
                end else begin
                    r.full = 1;
                end
            end
            CMD_CAST: begin
                for (int i = 0; i < sphere_cnt; i++) begin
                    d = sphere_dist(b, i);
                    if (d >= 0 && d < best) begin
                        best = d; r.idx = HIDX_W'(i); r.hit = 1;
                    end
                end
            end
            default: ;
        endcase
        r.distance = DIST_W'(best);
        return r;
    endfunction

    task automatic send_beat(beat_t b, bit typed, hit_t tr);
        int gap;
        hit_t pr;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_cmd    <= b.cmd;
        s_pos_x  <= b.px; s_pos_y <= b.py; s_pos_z <= b.pz;
        s_radius <= b.rad;
        s_dir_x  <= b.dx; s_dir_y <= b.dy; s_dir_z <= b.dz;
        do @(posedge aclk); while (!s_ready);
        pr = nearest_hit_predict(b);
        if (typed && pr != tr) begin
            $error("typed row disagrees with predictor: cmd %0d", b.cmd);
            err_cnt++;
        end
        hit_expect_q = {hit_expect_q, (typed ? tr : pr)};
    endtask

    task automatic write_limit(logic [DIST_W-1:0] v);
        s_valid <= 1'b0;
        while (hit_expect_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        dist_limit  = v;
    endtask

    function automatic beat_t mk(logic [CMD_W-1:0] c, int x, int y, int z, int r,
                                 int ux, int uy, int uz);
        beat_t b;
        b.cmd = c; b.px = x; b.py = y; b.pz = z; b.rad = RAD_W'(r);
        b.dx = DIR_W'(ux); b.dy = DIR_W'(uy); b.dz = DIR_W'(uz);
        return b;
    endfunction

    function automatic int rpos(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic beat_t noise_beat();
        beat_t b;
        b.cmd = CMD_W'($urandom_range(0, 3));
        b.px = $urandom; b.py = $urandom; b.pz = $urandom;
        b.rad = RAD_W'($urandom);
        b.dx = DIR_W'($urandom); b.dy = DIR_W'($urandom); b.dz = DIR_W'($urandom);
        return b;
    endfunction

    function automatic beat_t sphere_beat();
        return mk(CMD_APPEND, rpos(40 * Q), rpos(40 * Q), rpos(40 * Q),
                  $urandom_range(0, 10 * Q), 0, 0, 0);
    endfunction

    // ray from a random origin, mostly aimed near a stored sphere
    function automatic beat_t ray_beat();
        beat_t b;
        real vx, vy, vz, len;
        int  k;
        b = mk(CMD_CAST, rpos(50 * Q), rpos(50 * Q), rpos(50 * Q), $urandom, 0, 0, 0);
        if (sphere_cnt > 0 && $urandom_range(0, 4) != 0) begin
            k  = $urandom_range(0, sphere_cnt - 1);
            vx = real'(ctr_x[k] - b.px) + real'(rpos(2 * Q));
            vy = real'(ctr_y[k] - b.py) + real'(rpos(2 * Q));
            vz = real'(ctr_z[k] - b.pz) + real'(rpos(2 * Q));
        end else begin
            vx = real'(rpos(Q)); vy = real'(rpos(Q)); vz = real'(rpos(Q));
        end
        len = $sqrt(vx * vx + vy * vy + vz * vz);
        if (len < 1.0) begin
            vx = 1.0; len = 1.0;
        end
        b.dx = DIR_W'($rtoi(vx / len * 65536.0));
        b.dy = DIR_W'($rtoi(vy / len * 65536.0));
        b.dz = DIR_W'($rtoi(vz / len * 65536.0));
        return b;
    endfunction

    task automatic random_run(int n);
        hit_t none;
        int   k, na, nc;
        none = '{0, 0, 0, 0};
        k = 0;
        while (k < n) begin
            if ($urandom_range(0, 9) < 2) begin
                send_beat(noise_beat(), 0, none);
                k++;
            end else begin
                if ($urandom_range(0, 2) == 0 || sphere_cnt > 12) begin
                    send_beat(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0), 0, none);
                    k++;
                end
                na = $urandom_range(1, 5);
                nc = $urandom_range(1, 4);
                repeat (na) send_beat(sphere_beat(), 0, none);
                repeat (nc) send_beat(ray_beat(), 0, none);
                k += na + nc;
            end
        end
    endtask

    // monitor
    always @(posedge aclk) begin
        hit_t e;
        if (aresetn && m_valid && m_ready) begin
            if (hit_expect_q.size() == 0) begin
                $error("result beat with nothing expected");
                err_cnt++;
            end else begin
                e = hit_expect_q.pop_front();
                if (m_hit !== e.hit) begin
                    $error("hit: expected %0d, got %0d", e.hit, m_hit); err_cnt++;
                end
                if (m_hit_index !== e.idx) begin
                    $error("hit_index: expected %0d, got %0d", e.idx, m_hit_index);
                    err_cnt++;
                end
                if (m_hit_distance !== e.distance) begin
                    $error("hit_distance: expected %0d, got %0d", e.distance,
                           m_hit_distance);
                    err_cnt++;
                end
                if (m_table_full !== e.full) begin
                    $error("table_full: expected %0d, got %0d", e.full, m_table_full);
                    err_cnt++;
                end
            end
        end
    end

    // result-side stalls
    int stall_left;
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 6);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("nearest_ray_sphere_hit_tb: done, errors");
                $finish;
            end
        end
    end

    row_t dir_rows[$];
    hit_t none_r, miss_r;

    initial begin
        logic [DIST_W-1:0] md;
        aresetn <= 1'b0; cfg_wr_en <= 1'b0; cfg_wr_data <= '0;
        s_valid <= 1'b0; s_cmd <= '0; s_pos_x <= '0; s_pos_y <= '0; s_pos_z <= '0;
        s_radius <= '0; s_dir_x <= '0; s_dir_y <= '0; s_dir_z <= '0;
        m_ready <= 1'b0;
        stall_left = 0; idle_cycles = 0; err_cnt = 0; calm = 0;
        sphere_cnt = 0; dist_limit = MAX_DIST_RESET;
        md = MAX_DIST_RESET;
        none_r = '{0, 0, md, 0};
        miss_r = none_r;

        dir_rows = '{
            '{mk(CMD_CAST, 0, 0, 0, 0, Q, 0, 0), 1, miss_r},
            '{mk(CMD_NOP, -1, -1, -1, 32'h7fffffff, -1, -1, -1), 1, none_r},
            '{mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, none_r},
            '{mk(CMD_APPEND, 10 * Q, 0, 0, Q, 0, 0, 0), 1, none_r},
            '{mk(CMD_CAST, 0, 0, 0, 0, Q, 0, 0), 1, '{1, 0, 31'd589824, 0}},
            '{mk(CMD_CAST, 0, 0, 0, 0, -Q, 0, 0), 1, miss_r},
            '{mk(CMD_APPEND, 10 * Q, 0, 0, Q, 0, 0, 0), 1, none_r},
            '{mk(CMD_CAST, 0, 0, 0, 0, Q, 0, 0), 1, '{1, 0, 31'd589824, 0}},
            '{mk(CMD_CAST, 10 * Q, 0, 0, 0, 0, Q, 0), 0, none_r},
            '{mk(CMD_APPEND, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                 0, 0, 0), 1, none_r},
            '{mk(CMD_CAST, 0, 0, 0, 0, -131072, 131071, -131072), 0, none_r},
            '{mk(CMD_CAST, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0,
                 131071, -131072, 131071), 0, none_r},
            '{mk(CMD_APPEND, 0, 0, 30 * Q, 2 * Q, 0, 0, 0), 1, none_r},
            '{mk(CMD_CAST, 0, 0, 0, 0, 0, 0, Q), 0, none_r},
            '{mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, none_r},
            '{mk(CMD_CAST, 0, 0, 0, 0, Q, 0, 0), 1, miss_r},
            '{mk(CMD_APPEND, 5 * Q, 0, 0, 0, 0, 0, 0), 1, none_r},
            '{mk(CMD_CAST, 0, 0, 0, 0, Q, 0, 0), 0, none_r},
            '{mk(CMD_APPEND, 5 * Q, Q, 0, Q, 0, 0, 0), 1, none_r},
            '{mk(CMD_CAST, 0, 0, 0, 0, Q, 0, 0), 0, none_r}
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) send_beat(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].r);

        write_limit('0);
        random_run(60);
        write_limit(31'h7fffffff);
        random_run(150);
        write_limit(31'd2621440);
        random_run(120);

        // fill the table, overflow it, cast over all entries
        write_limit(MAX_DIST_RESET);
        send_beat(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0), 0, none_r);
        repeat (MAX_SPHERES) send_beat(sphere_beat(), 0, none_r);
        send_beat(sphere_beat(), 0, none_r);
        send_beat(noise_beat(), 0, none_r);
        repeat (2) send_beat(ray_beat(), 0, none_r);
        send_beat(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0), 0, none_r);

        random_run(120);
        calm = 1;
        random_run(100);

        s_valid <= 1'b0;
        while (hit_expect_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("nearest_ray_sphere_hit_tb: done, clean");
        end else begin
            $display("nearest_ray_sphere_hit_tb: done, errors");
        end
        $finish;
    end
endmodule

// File: files.f
hw/rtl/nrsh_pkg.sv
hw/rtl/nrsh_datapath.sv
hw/rtl/nrsh_ctrl.sv
hw/rtl/nearest_ray_sphere_hit.sv
tb/nearest_ray_sphere_hit_tb.sv
